// ===== sv/qte_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and fixed-point helpers for the quintic trajectory evaluator.
// No dependencies.
package qte_pkg;

    // default segment capacity
    localparam int MAX_SEGMENTS_DEF = 16;

    // input operation codes
    localparam logic [1:0] OP_WCOEF = 2'd0;
    localparam logic [1:0] OP_WDUR  = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    // highest axis and power accepted on a coefficient write
    localparam logic [1:0] AXIS_MAX  = 2'd2;
    localparam logic [2:0] POWER_MAX = 3'd5;
    localparam int COEFS_PER_AXIS = 6;
    localparam int AXES = 3;

    // derivative scale factors
    localparam logic [4:0] K_V5  = 5'd5;
    localparam logic [4:0] K_V4  = 5'd4;
    localparam logic [4:0] K_V3  = 5'd3;
    localparam logic [4:0] K_V2  = 5'd2;
    localparam logic [4:0] K_A20 = 5'd20;
    localparam logic [4:0] K_A12 = 5'd12;
    localparam logic [4:0] K_A6  = 5'd6;
    localparam logic [4:0] K_A2  = 5'd2;

    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

    // per-lane horner controls
    typedef struct packed {
        logic load;
        logic mul;
        logic upd;
    } lane_ctrl_t;

    // clamp a 49-bit signed sum to 48 bits
    function automatic logic signed [47:0] sat49(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v[48] != v[47])
            r = v[48] ? MIN48 : MAX48;
        else
            r = v[47:0];
        return r;
    endfunction

    // small unsigned scale of a coefficient, saturated to 48 bits
    function automatic logic signed [47:0] scale_sat(input logic signed [47:0] c,
                                                     input logic [4:0] m);
        logic signed [53:0] cx;
        logic signed [53:0] mx;
        logic signed [53:0] p;
        logic signed [47:0] r;
        cx = 54'(c);
        mx = 54'(signed'({1'b0, m}));
        p  = cx * mx;
        if (p > 54'(MAX48))
            r = MAX48;
        else if (p < 54'(MIN48))
            r = MIN48;
        else
            r = p[47:0];
        return r;
    endfunction

    // Q16.32 to Q16.16 with round half up and saturation
    function automatic logic [31:0] to_q16(input logic signed [47:0] v);
        logic [48:0] s;
        logic [32:0] off;
        logic [31:0] r;
        s   = {1'b0, ~v[47], v[46:0]} + 49'h8000;
        off = s[48:16];
        if (off[32])
            r = 32'hFFFF_FFFF ^ 32'h8000_0000;
        else
            r = off[31:0] ^ 32'h8000_0000;
        return r;
    endfunction

endpackage

// ===== sv/qte_lane.sv =====
`timescale 1ns / 1ps
// One horner lane: accumulator times Q16.16 time, rounded, plus coefficient.
// Depends on qte_pkg.
module qte_lane
    import qte_pkg::*;
(
    input  logic               clk,
    input  lane_ctrl_t         ctrl,
    input  logic signed [47:0] load_value,
    input  logic [31:0]        t,
    input  logic signed [47:0] k,
    output logic signed [47:0] acc
);

    logic signed [47:0] acc_reg;
    logic [63:0]        phi_reg;
    logic [63:0]        plo_reg;
    logic               neg_reg;

    logic [47:0]        mag;
    logic [63:0]        rnd;
    logic [65:0]        q;
    logic signed [47:0] prod;
    logic signed [47:0] sum_sat;

    // magnitude of the accumulator
    assign mag = acc_reg[47] ? (48'd0 - acc_reg) : acc_reg;

    // rounded product and signed saturation
    always_comb
    begin
        rnd = plo_reg + 64'h8000;
        q   = 66'(phi_reg) + 66'(rnd[63:16]);
        if (neg_reg)
        begin
            if (q >= 66'h8000_0000_0000)
                prod = MIN48;
            else
                prod = 48'd0 - q[47:0];
        end
        else
        begin
            if (q > 66'(MAX48))
                prod = MAX48;
            else
                prod = q[47:0];
        end
        sum_sat = sat49(49'(prod) + 49'(k));
    end

    // partial products, then accumulate
    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            phi_reg <= 64'(mag) * 64'(t[31:16]);
            plo_reg <= 64'(mag) * 64'(t[15:0]);
            neg_reg <= acc_reg[47];
        end
        if (ctrl.load)
            acc_reg <= load_value;
        else if (ctrl.upd)
            acc_reg <= sum_sat;
    end

    assign acc = acc_reg;

endmodule

// ===== sv/quintic_trajectory_evaluator.sv =====
`timescale 1ns / 1ps
// Top level of the quintic trajectory evaluator: stores, sequencer, result register.
// Depends on qte_pkg and qte_lane.
//
// Usage:
//   Input channel (in_valid/in_stall) carries load and evaluate items. Op 0 writes one
//   Q16.32 coefficient, op 1 writes one segment duration; both arm the trajectory. Op 2
//   evaluates at time_value and, while armed, gives one result on the output channel
//   (out_valid/out_stall) with position, velocity and acceleration for x, y and z in
//   Q16.16, the segment used and a finished flag.
//   An evaluation scans the n segments in use in the duration memory, then per axis
//   reads the coefficient memory, loads the lanes, runs five horner steps (each a
//   multiply and an add) shared by three lanes (position, velocity, acceleration) and
//   rounds. in_stall stays high until its result is in the output register; loads
//   take one a cycle while no evaluation is running.
//   A finished result waits in the output register while the next item is taken; a
//   new result is held back until the receiver has taken the old one.
//   cfg_we/cfg_wdata set segment_count; write it only while the block is idle.
//   Reset disarms the trajectory and sets segment_count to 1; the stores hold nothing
//   valid until written.
module quintic_trajectory_evaluator
    import qte_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [3:0]         segment,
    input  logic [1:0]         axis,
    input  logic [2:0]         coeff_index,
    input  logic signed [47:0] coeff_value,
    input  logic [31:0]        time_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    output logic signed [31:0] acc_x,
    output logic signed [31:0] acc_y,
    output logic signed [31:0] acc_z,
    output logic               finished,
    output logic [3:0]         segment_used
);

    localparam int SW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CDEP = MAX_SEGMENTS * AXES * COEFS_PER_AXIS;
    localparam int CAW  = $clog2(CDEP);
    localparam int SUMW = 37;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_INIT = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_ADD  = 3'd5;
    localparam logic [2:0] S_AXIS = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [2:0] STEP_LAST = 3'd5;
    localparam logic [2:0] LOAD_LAST = 3'd6;
    localparam logic [1:0] AXIS_LAST = 2'd2;

    // stores
    logic signed [47:0] coef_mem [CDEP];
    logic [31:0]        dur_mem [MAX_SEGMENTS];
    logic signed [47:0] coef_q;
    logic [31:0]        dur_q;
    logic [CAW-1:0]     coef_wa;
    logic [CAW-1:0]     coef_ra;
    logic [SW-1:0]      dur_ra;

    // control and working registers
    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic               armed_reg;
    logic [4:0]         seg_cnt_reg;
    logic [4:0]         n_reg;
    logic [4:0]         p_reg;
    logic [SUMW-1:0]    cum_reg;
    logic               found_reg;
    logic               fin_reg;
    logic [SW-1:0]      idx_reg;
    logic [31:0]        tv_reg;
    logic [31:0]        tl_reg;
    logic [1:0]         a_reg;
    logic [2:0]         j_reg;
    logic [2:0]         s_reg;
    logic signed [47:0] c_reg [COEFS_PER_AXIS];
    logic [31:0]        rp_reg [AXES];
    logic [31:0]        rv_reg [AXES];
    logic [31:0]        ra_reg [AXES];
    logic               out_valid_reg;
    logic [31:0]        op_reg [9];
    logic               ofin_reg;
    logic [3:0]         oseg_reg;

    // combinational helpers
    logic               accept;
    logic               seg_ok;
    logic               wr_coef;
    logic               wr_dur;
    logic               do_eval;
    logic [4:0]         n_eff;
    logic [SUMW-1:0]    sum;
    logic               hit;
    logic               last;
    logic               out_free;

    lane_ctrl_t         ctrl_p;
    lane_ctrl_t         ctrl_v;
    lane_ctrl_t         ctrl_a;
    logic signed [47:0] kp;
    logic signed [47:0] kv;
    logic signed [47:0] ka;
    logic signed [47:0] acc_p;
    logic signed [47:0] acc_v;
    logic signed [47:0] acc_a;

    // input decode
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign seg_ok   = (32'(segment) < MAX_SEGMENTS);
    assign wr_coef  = accept && (op == OP_WCOEF) && seg_ok && (axis <= AXIS_MAX)
                      && (coeff_index <= POWER_MAX);
    assign wr_dur   = accept && (op == OP_WDUR) && seg_ok;
    assign do_eval  = accept && (op == OP_EVAL) && armed_reg;
    assign out_free = !out_valid_reg || !out_stall;

    // effective segment count
    always_comb
    begin
        if (seg_cnt_reg == 5'd0)
            n_eff = 5'd1;
        else if (32'(seg_cnt_reg) > MAX_SEGMENTS)
            n_eff = 5'(MAX_SEGMENTS);
        else
            n_eff = seg_cnt_reg;
    end

    // store addressing
    assign coef_wa = CAW'((32'(segment) * AXES + 32'(axis)) * COEFS_PER_AXIS
                          + 32'(coeff_index));
    assign coef_ra = CAW'((32'(idx_reg) * AXES + 32'(a_reg)) * COEFS_PER_AXIS
                          + 32'(j_reg));
    assign dur_ra  = (state_reg == S_SCAN) ? SW'(p_reg + 5'd1) : '0;

    // coefficient memory
    always_ff @(posedge clk)
    begin
        if (wr_coef)
            coef_mem[coef_wa] <= coeff_value;
        coef_q <= coef_mem[coef_ra];
    end

    // duration memory
    always_ff @(posedge clk)
    begin
        if (wr_dur)
            dur_mem[SW'(segment)] <= time_value;
        dur_q <= dur_mem[dur_ra];
    end

    // window scan step
    assign sum  = cum_reg + SUMW'(dur_q);
    assign hit  = !found_reg && (SUMW'(tv_reg) < sum);
    assign last = (p_reg == (n_reg - 5'd1));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (do_eval) state_next = S_SCAN;
            S_SCAN: if (last) state_next = S_LOAD;
            S_LOAD: if (j_reg == LOAD_LAST) state_next = S_INIT;
            S_INIT: state_next = S_MUL;
            S_MUL:  state_next = S_ADD;
            S_ADD:  state_next = (s_reg == STEP_LAST) ? S_AXIS : S_MUL;
            S_AXIS: state_next = (a_reg == AXIS_LAST) ? S_DONE : S_LOAD;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            armed_reg     <= 1'b0;
            seg_cnt_reg   <= 5'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                seg_cnt_reg <= cfg_wdata;
            if (wr_coef || wr_dur)
                armed_reg <= 1'b1;
            else if (state_reg == S_DONE && out_free && fin_reg)
                armed_reg <= 1'b0;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                tv_reg    <= time_value;
                n_reg     <= n_eff;
                p_reg     <= 5'd0;
                cum_reg   <= '0;
                found_reg <= 1'b0;
            end
            S_SCAN:
            begin
                cum_reg <= sum;
                p_reg   <= p_reg + 5'd1;
                if (hit)
                begin
                    found_reg <= 1'b1;
                    idx_reg   <= SW'(p_reg);
                    tl_reg    <= tv_reg - cum_reg[31:0];
                end
                if (last)
                begin
                    fin_reg <= (SUMW'(tv_reg) >= sum);
                    if (SUMW'(tv_reg) >= sum)
                    begin
                        idx_reg <= SW'(p_reg);
                        tl_reg  <= dur_q;
                    end
                    a_reg <= 2'd0;
                    j_reg <= 3'd0;
                end
            end
            S_LOAD:
            begin
                if (j_reg != 3'd0)
                    c_reg[j_reg - 3'd1] <= coef_q;
                j_reg <= j_reg + 3'd1;
            end
            S_INIT:
            begin
                s_reg <= 3'd1;
            end
            S_ADD:
            begin
                s_reg <= s_reg + 3'd1;
            end
            S_AXIS:
            begin
                rp_reg[a_reg] <= to_q16(acc_p);
                rv_reg[a_reg] <= to_q16(acc_v);
                ra_reg[a_reg] <= to_q16(acc_a);
                a_reg         <= a_reg + 2'd1;
                j_reg         <= 3'd0;
            end
            default:
            begin
            end
        endcase
    end

    // coefficient selection per horner step
    always_comb
    begin
        case (s_reg)
            3'd1:    kp = c_reg[4];
            3'd2:    kp = c_reg[3];
            3'd3:    kp = c_reg[2];
            3'd4:    kp = c_reg[1];
            default: kp = c_reg[0];
        endcase
        case (s_reg)
            3'd2:    kv = scale_sat(c_reg[4], K_V4);
            3'd3:    kv = scale_sat(c_reg[3], K_V3);
            3'd4:    kv = scale_sat(c_reg[2], K_V2);
            default: kv = c_reg[1];
        endcase
        case (s_reg)
            3'd3:    ka = scale_sat(c_reg[4], K_A12);
            3'd4:    ka = scale_sat(c_reg[3], K_A6);
            default: ka = scale_sat(c_reg[2], K_A2);
        endcase
    end

    // lane controls: velocity and acceleration join one and two steps late
    always_comb
    begin
        ctrl_p.load = (state_reg == S_INIT);
        ctrl_p.mul  = (state_reg == S_MUL);
        ctrl_p.upd  = (state_reg == S_ADD);
        ctrl_v      = ctrl_p;
        ctrl_a      = ctrl_p;
        ctrl_v.upd  = (state_reg == S_ADD) && (s_reg >= 3'd2);
        ctrl_a.upd  = (state_reg == S_ADD) && (s_reg >= 3'd3);
    end

    qte_lane u_lane_pos (
        .clk        (clk),
        .ctrl       (ctrl_p),
        .load_value (c_reg[5]),
        .t          (tl_reg),
        .k          (kp),
        .acc        (acc_p)
    );

    qte_lane u_lane_vel (
        .clk        (clk),
        .ctrl       (ctrl_v),
        .load_value (scale_sat(c_reg[5], K_V5)),
        .t          (tl_reg),
        .k          (kv),
        .acc        (acc_v)
    );

    qte_lane u_lane_acc (
        .clk        (clk),
        .ctrl       (ctrl_a),
        .load_value (scale_sat(c_reg[5], K_A20)),
        .t          (tl_reg),
        .k          (ka),
        .acc        (acc_a)
    );

    // output register, loaded when the previous transfer is done
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            op_reg[0] <= rp_reg[0];
            op_reg[1] <= rp_reg[1];
            op_reg[2] <= rp_reg[2];
            op_reg[3] <= rv_reg[0];
            op_reg[4] <= rv_reg[1];
            op_reg[5] <= rv_reg[2];
            op_reg[6] <= ra_reg[0];
            op_reg[7] <= ra_reg[1];
            op_reg[8] <= ra_reg[2];
            ofin_reg  <= fin_reg;
            oseg_reg  <= 4'(idx_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign pos_x        = op_reg[0];
    assign pos_y        = op_reg[1];
    assign pos_z        = op_reg[2];
    assign vel_x        = op_reg[3];
    assign vel_y        = op_reg[4];
    assign vel_z        = op_reg[5];
    assign acc_x        = op_reg[6];
    assign acc_y        = op_reg[7];
    assign acc_z        = op_reg[8];
    assign finished     = ofin_reg;
    assign segment_used = oseg_reg;

endmodule

// ===== test/qte_checker.sv =====
`timescale 1ns / 1ps
// Checker for the quintic trajectory evaluator: watches the config port and both channels,
// predicts each trajectory point and compares it with the block output. Depends on qte_pkg.
module qte_checker
    import qte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_wdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         op,
    input  logic [3:0]         segment,
    input  logic [1:0]         axis,
    input  logic [2:0]         coeff_index,
    input  logic signed [47:0] coeff_value,
    input  logic [31:0]        time_value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [31:0] acc_x,
    input  logic signed [31:0] acc_y,
    input  logic signed [31:0] acc_z,
    input  logic               finished,
    input  logic [3:0]         segment_used,
    output int                 mismatch_count,
    output int                 points_pending,
    output int                 points_checked
);

    localparam longint Q_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint Q_MIN = -64'sh0000_7FFF_FFFF_FFFF - 1;
    localparam int NSEG = MAX_SEGMENTS_DEF;

    typedef struct {
        logic [31:0] kin[9];
        logic        fin;
        logic [3:0]  seg;
    } traj_point_t;

    longint      coef_mem[NSEG * 18];
    logic [31:0] dur_mem[NSEG];
    logic        armed;
    logic [4:0]  seg_count;
    traj_point_t point_q[$];

    function automatic longint clamp48(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // multiply a Q16.32 value by a Q16.16 time, magnitude rounded half away from zero
    function automatic longint times_t(input longint a, input logic [31:0] t);
        longint unsigned m;
        longint unsigned q;
        m = (a < 0) ? longint'(-a) : longint'(a);
        q = m * t[31:16] + ((m * t[15:0] + 64'h8000) >> 16);
        if (a < 0)
        begin
            if (q >= 64'h0000_8000_0000_0000) return Q_MIN;
            return -longint'(q);
        end
        if (q > 64'h0000_7FFF_FFFF_FFFF) return Q_MAX;
        return longint'(q);
    endfunction

    // horner evaluation, k[0] is the highest power
    function automatic longint horner_eval(input longint k[6], input int n, input logic [31:0] t);
        longint acc;
        acc = k[0];
        for (int i = 1; i < n; i++)
            acc = clamp48(times_t(acc, t) + k[i]);
        return acc;
    endfunction

    function automatic logic [31:0] q32_to_q16(input longint v);
        longint unsigned off;
        off = (longint'(v + 64'sh0000_8000_0000_0000) + 64'h8000) >> 16;
        if (off > 64'hFFFF_FFFF) off = 64'hFFFF_FFFF;
        return 32'(off - 64'h8000_0000);
    endfunction

    // trajectory point at elapsed time t
    function automatic traj_point_t eval_point(input logic [31:0] t);
        traj_point_t pt;
        int n;
        int idx;
        longint unsigned total;
        longint unsigned cum;
        logic [31:0] tl;
        longint c[6];
        longint kp[6];
        longint kv[6];
        longint ka[6];
        n = (seg_count == 0) ? 1 : (seg_count > NSEG) ? NSEG : int'(seg_count);
        total = 0;
        cum = 0;
        idx = 0;
        tl = 0;
        for (int i = 0; i < n; i++) total += dur_mem[i];
        pt.fin = (longint'(t) >= total);
        if (pt.fin)
        begin
            idx = n - 1;
            tl = dur_mem[idx];
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                if (longint'(t) < cum + dur_mem[i])
                begin
                    idx = i;
                    tl = 32'(longint'(t) - cum);
                    break;
                end
                cum += dur_mem[i];
            end
        end
        for (int a = 0; a < AXES; a++)
        begin
            for (int p = 0; p < 6; p++) c[p] = coef_mem[(idx * 3 + a) * 6 + p];
            kp = '{c[5], c[4], c[3], c[2], c[1], c[0]};
            kv = '{clamp48(5 * c[5]), clamp48(4 * c[4]), clamp48(3 * c[3]),
                   clamp48(2 * c[2]), c[1], 0};
            ka = '{clamp48(20 * c[5]), clamp48(12 * c[4]), clamp48(6 * c[3]),
                   clamp48(2 * c[2]), 0, 0};
            pt.kin[a]     = q32_to_q16(horner_eval(kp, 6, tl));
            pt.kin[3 + a] = q32_to_q16(horner_eval(kv, 5, tl));
            pt.kin[6 + a] = q32_to_q16(horner_eval(ka, 4, tl));
        end
        pt.seg = 4'(idx);
        return pt;
    endfunction

    // predict on every armed evaluation transfer, compare on every output transfer
    always @(posedge clk or negedge rst_n)
    begin
        traj_point_t want;
        logic [31:0] got[9];
        if (!rst_n)
        begin
            armed <= 1'b0;
            seg_count <= 5'd1;
            mismatch_count <= 0;
            points_checked <= 0;
            points_pending <= 0;
        end
        else
        begin
            if (cfg_we)
                seg_count <= cfg_wdata;
            if (in_valid && !in_stall)
            begin
                if (op == OP_WCOEF)
                begin
                    if (axis <= AXIS_MAX && coeff_index <= POWER_MAX)
                    begin
                        coef_mem[(int'(segment) * 3 + int'(axis)) * 6 + int'(coeff_index)]
                            = longint'(coeff_value);
                        armed <= 1'b1;
                    end
                end
                else if (op == OP_WDUR)
                begin
                    dur_mem[segment] = time_value;
                    armed <= 1'b1;
                end
                else if (op == OP_EVAL && armed)
                begin
                    want = eval_point(time_value);
                    point_q = {point_q, want};
                    if (want.fin)
                        armed <= 1'b0;
                end
            end
            if (out_valid && !out_stall)
            begin
                got = '{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z};
                points_checked <= points_checked + 1;
                if (point_q.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("ERROR: unexpected result transfer at %0t", $realtime);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = point_q.pop_front();
                    if (got != want.kin || finished != want.fin || segment_used != want.seg)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display({"ERROR at %0t: expected pos %h %h %h vel %h %h %h",
                                      " acc %h %h %h fin %b seg %0d"},
                                     $realtime, want.kin[0], want.kin[1], want.kin[2],
                                     want.kin[3], want.kin[4], want.kin[5], want.kin[6],
                                     want.kin[7], want.kin[8], want.fin, want.seg);
                            $display({"       actual   pos %h %h %h vel %h %h %h",
                                      " acc %h %h %h fin %b seg %0d"},
                                     got[0], got[1], got[2], got[3], got[4], got[5],
                                     got[6], got[7], got[8], finished, segment_used);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            points_pending <= point_q.size();
        end
    end

endmodule

// ===== test/tb_quintic_trajectory_evaluator.sv =====
`timescale 1ns / 1ps
// Testbench top for the quintic trajectory evaluator: clock, reset, stimulus and verdict.
// Depends on qte_pkg, qte_checker and the block itself.
module tb_quintic_trajectory_evaluator
    import qte_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [4:0]         cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         op;
    logic [3:0]         segment;
    logic [1:0]         axis;
    logic [2:0]         coeff_index;
    logic signed [47:0] coeff_value;
    logic [31:0]        time_value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] vel_x, vel_y, vel_z;
    logic signed [31:0] acc_x, acc_y, acc_z;
    logic               finished;
    logic [3:0]         segment_used;
    int                 mismatch_count;
    int                 points_pending;
    int                 points_checked;

    int          send_idle;
    int          recv_idle;
    int          items_sent;
    int          quiet_cycles;
    logic [31:0] dur_shadow[16];

    quintic_trajectory_evaluator dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .op(op), .segment(segment),
        .axis(axis), .coeff_index(coeff_index), .coeff_value(coeff_value),
        .time_value(time_value), .out_valid(out_valid), .out_stall(out_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
        .finished(finished), .segment_used(segment_used)
    );

    qte_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .op(op), .segment(segment),
        .axis(axis), .coeff_index(coeff_index), .coeff_value(coeff_value),
        .time_value(time_value), .out_valid(out_valid), .out_stall(out_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
        .finished(finished), .segment_used(segment_used),
        .mismatch_count(mismatch_count), .points_pending(points_pending),
        .points_checked(points_checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stalls at random
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle);

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // one input transfer; called and returning at a falling edge
    task automatic send_item(input logic [1:0] o, input logic [3:0] s, input logic [1:0] a,
                             input logic [2:0] p, input logic [47:0] c, input logic [31:0] t);
        logic stalled;
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        op <= o;
        segment <= s;
        axis <= a;
        coeff_index <= p;
        coeff_value <= c;
        time_value <= t;
        in_valid <= 1'b1;
        forever
        begin
            #1 stalled = in_stall;
            @(posedge clk);
            if (!stalled)
                break;
            @(negedge clk);
        end
        @(negedge clk);
        items_sent++;
        if (o == OP_WDUR)
            dur_shadow[s] = t;
    endtask

    // set segment_count once the block has gone quiet
    task automatic set_segment_count(input logic [4:0] v);
        in_valid <= 1'b0;
        while (points_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [47:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 48'h7FFF_FFFF_FFFF;
            1: return 48'h8000_0000_0000;
            2, 3: return 48'({$urandom, $urandom});
            4, 5, 6: return 48'(signed'($urandom_range(0, 32'hFFFF_FFFF)) <<< 2);
            default: return 48'(signed'(32'($urandom)) >>> 4);
        endcase
    endfunction

    function automatic logic [31:0] pick_duration();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom;
            default: return $urandom_range(32'h0000_4000, 32'h0003_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_time();
        logic [31:0] acc;
        int k;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            2, 3:
            begin
                // exactly on a segment boundary
                acc = 0;
                k = $urandom_range(0, 16);
                for (int i = 0; i < k; i++) acc += dur_shadow[i];
                return acc;
            end
            default: return $urandom_range(0, 32'h0030_0000);
        endcase
    endfunction

    // one random item: mostly loads and evaluations, some ignored writes and noise
    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            send_item(OP_EVAL, 4'($urandom), 2'($urandom), 3'($urandom),
                      48'({$urandom, $urandom}), pick_time());
        else if (r < 75)
            send_item(OP_WCOEF, 4'($urandom), 2'($urandom_range(0, 2)), 3'($urandom_range(0, 5)),
                      pick_coef(), $urandom);
        else if (r < 88)
            send_item(OP_WDUR, 4'($urandom), 2'($urandom), 3'($urandom),
                      48'({$urandom, $urandom}), pick_duration());
        else if (r < 95)
            send_item(OP_WCOEF, 4'($urandom), 2'd3, 3'($urandom_range(6, 7)),
                      48'({$urandom, $urandom}), $urandom);
        else
            send_item(2'd3, 4'($urandom), 2'($urandom), 3'($urandom),
                      48'({$urandom, $urandom}), $urandom);
    endtask

    initial
    begin
        logic [4:0] count_list[8];
        count_list = '{5'd1, 5'd16, 5'd0, 5'd17, 5'd31, 5'd8, 5'd2, 5'd15};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        op = '0;
        segment = '0;
        axis = '0;
        coeff_index = '0;
        coeff_value = '0;
        time_value = '0;
        out_stall = 1'b0;
        send_idle = 34;
        recv_idle = 83;
        items_sent = 0;
        quiet_cycles = 0;
        for (int i = 0; i < 16; i++) dur_shadow[i] = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // disarmed: evaluation, unused op and out-of-range writes give nothing and do not arm
        send_item(OP_EVAL, 4'd0, 2'd0, 3'd0, 48'd0, 32'd0);
        send_item(2'd3, 4'hF, 2'd3, 3'd7, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_WCOEF, 4'd0, 2'd3, 3'd0, 48'd1, 32'd0);
        send_item(OP_WCOEF, 4'd0, 2'd0, 3'd6, 48'd1, 32'd0);
        send_item(OP_WCOEF, 4'd0, 2'd1, 3'd7, 48'd1, 32'd0);
        send_item(OP_EVAL, 4'd0, 2'd0, 3'd0, 48'd0, 32'd5);

        // fill both stores so that no evaluation reads an unwritten entry
        for (int s = 0; s < 16; s++)
        begin
            send_item(OP_WDUR, 4'(s), 2'd0, 3'd0, 48'd0, pick_duration());
            for (int a = 0; a < 3; a++)
                for (int p = 0; p < 6; p++)
                    send_item(OP_WCOEF, 4'(s), 2'(a), 3'(p), pick_coef(), 32'd0);
        end

        // single segment: start, past the end, disarmed, then rearm with extremes
        send_item(OP_EVAL, 4'd0, 2'd0, 3'd0, 48'd0, 32'd0);
        send_item(OP_EVAL, 4'd0, 2'd0, 3'd0, 48'd0, 32'hFFFF_FFFF);
        send_item(OP_EVAL, 4'd0, 2'd0, 3'd0, 48'd0, 32'd0);
        for (int p = 0; p < 6; p++)
            send_item(OP_WCOEF, 4'd0, 2'd0, 3'(p), 48'h7FFF_FFFF_FFFF, 32'd0);
        for (int p = 0; p < 6; p++)
            send_item(OP_WCOEF, 4'd0, 2'd1, 3'(p), 48'h8000_0000_0000, 32'd0);
        send_item(OP_WDUR, 4'd0, 2'd0, 3'd0, 48'd0, 32'hFFFF_FFFF);
        send_item(OP_EVAL, 4'd0, 2'd0, 3'd0, 48'd0, 32'hFFFF_FFFE);
        send_item(OP_EVAL, 4'd0, 2'd0, 3'd0, 48'd0, 32'h0001_0000);
        // zero total duration counts as finished
        send_item(OP_WDUR, 4'd0, 2'd0, 3'd0, 48'd0, 32'd0);
        send_item(OP_EVAL, 4'd0, 2'd0, 3'd0, 48'd0, 32'd0);
        send_item(OP_WDUR, 4'd0, 2'd0, 3'd0, 48'd0, 32'h0001_0000);

        // random part in three idling phases, segment_count changed between blocks
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 34 : (ph == 1) ? 83 : 0;
            recv_idle = (ph == 0) ? 83 : (ph == 1) ? 34 : 0;
            for (int b = 0; b < 5; b++)
            begin
                if (b < 3)
                    set_segment_count(count_list[(ph * 3 + b) % 8]);
                else
                    set_segment_count(5'($urandom_range(0, 31)));
                repeat (80) random_item();
            end
        end
        in_valid <= 1'b0;

        // drain
        while (points_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d input items over three stall patterns and 15 segment counts",
                 items_sent);
        $display("checked %0d trajectory points", points_checked);
        if (mismatch_count == 0 && points_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
